[hdl/table_driven_lexer_core_defines.svh]
// Assertion macros shared by the lexer core; they sample on clk and are disabled in rst.
`ifndef TABLE_DRIVEN_LEXER_CORE_DEFINES_SVH
`define TABLE_DRIVEN_LEXER_CORE_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define TDL_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define TDL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tdl_pkg.sv]
// Shared types, codes and keyword tables for the table-driven lexer core.
`timescale 1ns / 1ps

package tdl_pkg;

  // DFA states; the encoding follows the transition table rows.
  typedef enum logic [3:0] {
    ST_START = 4'd0,
    ST_IDENT = 4'd1,
    ST_NUM   = 4'd2,
    ST_SGL   = 4'd3,
    ST_FST   = 4'd4,
    ST_DBL   = 4'd5,
    ST_CM0   = 4'd6,
    ST_CM1   = 4'd7,
    ST_CM2   = 4'd8,
    ST_CM3   = 4'd9,
    ST_BAD   = 4'd10,
    ST_END   = 4'd11,
    ST_CM4   = 4'd12,
    ST_CM5   = 4'd13,
    ST_AGAIN = 4'd14
  } tdl_state_t;

  // Character classes that index the transition table columns.
  typedef enum logic [3:0] {
    CL_OTHER  = 4'd0,
    CL_DIGIT  = 4'd1,
    CL_LETTER = 4'd2,
    CL_SINGLE = 4'd3,
    CL_REL    = 4'd4,
    CL_EQUAL  = 4'd5,
    CL_SLASH  = 4'd6,
    CL_STAR   = 4'd7,
    CL_BLANK  = 4'd8
  } tdl_class_t;

  // Token kinds reported on the result channel.
  localparam logic [3:0] TK_ID        = 4'd0;
  localparam logic [3:0] TK_KEYWORD   = 4'd1;
  localparam logic [3:0] TK_NUMBER    = 4'd2;
  localparam logic [3:0] TK_SINGLE    = 4'd3;
  localparam logic [3:0] TK_FIRST     = 4'd4;
  localparam logic [3:0] TK_DOUBLE    = 4'd5;
  localparam logic [3:0] TK_SLASH     = 4'd6;
  localparam logic [3:0] TK_OPEN_CMT  = 4'd7;
  localparam logic [3:0] TK_OPEN_STAR = 4'd8;
  localparam logic [3:0] TK_COMMENT   = 4'd9;
  localparam logic [3:0] TK_ERROR     = 4'd10;
  localparam logic [3:0] TK_NONE      = 4'd15;

  // Error codes reported with an error token.
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_BAD_ID       = 3'd1;
  localparam logic [2:0] ERR_BAD_NUM      = 3'd2;
  localparam logic [2:0] ERR_NESTED_CMT   = 3'd3;
  localparam logic [2:0] ERR_REPEAT_DELIM = 3'd4;
  localparam logic [2:0] ERR_ILLEGAL      = 3'd5;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // Keyword table: lower-case text padded with zeros, and text lengths.
  localparam int KW_COUNT = 10;
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "r", "i", "t", "e", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "a", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"c", "a", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd2, 3'd4, 3'd3, 3'd5, 3'd2, 3'd3, 3'd5, 3'd4, 3'd6, 3'd4
  };

  // One input item as held in the input register.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } tdl_item_t;

  // One result item.
  typedef struct packed {
    logic [3:0]  token_kind;
    logic [3:0]  keyword_index;
    logic [2:0]  error_code;
    logic [15:0] line_number;
    logic [10:0] token_length;
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic        to_listing;
  } tdl_result_t;

endpackage

[hdl/tdl_in_stage.sv]
// Input register of the lexer core with its valid/stall handshake.
`timescale 1ns / 1ps

module tdl_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [7:0]        char_byte,
  input  logic              end_of_input,
  input  logic              advance,
  output logic              held_valid,
  output tdl_pkg::tdl_item_t held_item
);

  // The register is free when it is empty or its item moves on this cycle.
  assign item_stall = held_valid && !advance;

  // Valid bit of the held item.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  // Payload is captured only when an item is accepted.
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held_item.char_byte    <= char_byte;
      held_item.end_of_input <= end_of_input;
    end
  end

endmodule

[hdl/tdl_scan.sv]
// Lexer state registers and the combinational DFA step with keyword matching.
`timescale 1ns / 1ps

module tdl_scan #(
  parameter int MAX_TOKEN = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  tdl_pkg::tdl_item_t    item,
  output logic                  emit,
  output tdl_pkg::tdl_result_t  result
);

  localparam int LEN_CAP_INT = (MAX_TOKEN < 2047) ? MAX_TOKEN : 2047;
  localparam logic [10:0] LEN_CAP = 11'(LEN_CAP_INT);

  // Character class of one byte.
  function automatic tdl_pkg::tdl_class_t byte_class(input logic [7:0] c);
    tdl_pkg::tdl_class_t cls;
    case (c) inside
      [8'h30:8'h39]:                       cls = tdl_pkg::CL_DIGIT;
      [8'h41:8'h5A], [8'h61:8'h7A]:        cls = tdl_pkg::CL_LETTER;
      8'h2B, 8'h2D, 8'h3A, 8'h28, 8'h29,
      8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h2C,
      8'h3B:                               cls = tdl_pkg::CL_SINGLE;
      8'h3E, 8'h3C, 8'h21:                 cls = tdl_pkg::CL_REL;
      8'h3D:                               cls = tdl_pkg::CL_EQUAL;
      8'h2F:                               cls = tdl_pkg::CL_SLASH;
      8'h2A:                               cls = tdl_pkg::CL_STAR;
      8'h20, 8'h09:                        cls = tdl_pkg::CL_BLANK;
      default:                             cls = tdl_pkg::CL_OTHER;
    endcase
    return cls;
  endfunction

  // Transition table of the DFA.
  function automatic tdl_pkg::tdl_state_t next_state(input tdl_pkg::tdl_state_t s,
                                                     input tdl_pkg::tdl_class_t c);
    tdl_pkg::tdl_state_t n;
    n = tdl_pkg::ST_BAD;
    unique case (s)
      tdl_pkg::ST_START: begin
        unique case (c) inside
          tdl_pkg::CL_DIGIT:                    n = tdl_pkg::ST_NUM;
          tdl_pkg::CL_LETTER:                   n = tdl_pkg::ST_IDENT;
          tdl_pkg::CL_SINGLE, tdl_pkg::CL_STAR: n = tdl_pkg::ST_SGL;
          tdl_pkg::CL_REL, tdl_pkg::CL_EQUAL:   n = tdl_pkg::ST_FST;
          tdl_pkg::CL_SLASH:                    n = tdl_pkg::ST_CM0;
          tdl_pkg::CL_BLANK:                    n = tdl_pkg::ST_END;
          default:                              n = tdl_pkg::ST_BAD;
        endcase
      end
      tdl_pkg::ST_IDENT: begin
        unique case (c) inside
          tdl_pkg::CL_OTHER:                     n = tdl_pkg::ST_BAD;
          tdl_pkg::CL_DIGIT, tdl_pkg::CL_LETTER: n = tdl_pkg::ST_IDENT;
          tdl_pkg::CL_BLANK:                     n = tdl_pkg::ST_END;
          default:                               n = tdl_pkg::ST_AGAIN;
        endcase
      end
      tdl_pkg::ST_NUM: begin
        unique case (c) inside
          tdl_pkg::CL_OTHER, tdl_pkg::CL_LETTER: n = tdl_pkg::ST_BAD;
          tdl_pkg::CL_DIGIT:                     n = tdl_pkg::ST_NUM;
          tdl_pkg::CL_BLANK:                     n = tdl_pkg::ST_END;
          default:                               n = tdl_pkg::ST_AGAIN;
        endcase
      end
      tdl_pkg::ST_SGL: begin
        unique case (c) inside
          tdl_pkg::CL_OTHER, tdl_pkg::CL_SLASH, tdl_pkg::CL_STAR: n = tdl_pkg::ST_BAD;
          tdl_pkg::CL_BLANK:                                      n = tdl_pkg::ST_END;
          default:                                                n = tdl_pkg::ST_AGAIN;
        endcase
      end
      tdl_pkg::ST_FST: begin
        unique case (c) inside
          tdl_pkg::CL_DIGIT, tdl_pkg::CL_LETTER: n = tdl_pkg::ST_AGAIN;
          tdl_pkg::CL_EQUAL:                     n = tdl_pkg::ST_DBL;
          tdl_pkg::CL_BLANK:                     n = tdl_pkg::ST_END;
          default:                               n = tdl_pkg::ST_BAD;
        endcase
      end
      tdl_pkg::ST_DBL: begin
        unique case (c) inside
          tdl_pkg::CL_OTHER, tdl_pkg::CL_REL,
          tdl_pkg::CL_SLASH, tdl_pkg::CL_STAR:   n = tdl_pkg::ST_BAD;
          tdl_pkg::CL_BLANK:                     n = tdl_pkg::ST_END;
          default:                               n = tdl_pkg::ST_AGAIN;
        endcase
      end
      tdl_pkg::ST_CM0: begin
        unique case (c) inside
          tdl_pkg::CL_SLASH: n = tdl_pkg::ST_CM4;
          tdl_pkg::CL_STAR:  n = tdl_pkg::ST_CM1;
          tdl_pkg::CL_BLANK: n = tdl_pkg::ST_END;
          default:           n = tdl_pkg::ST_BAD;
        endcase
      end
      tdl_pkg::ST_CM1: begin
        unique case (c) inside
          tdl_pkg::CL_STAR: n = tdl_pkg::ST_CM2;
          default:          n = tdl_pkg::ST_CM1;
        endcase
      end
      tdl_pkg::ST_CM2: begin
        unique case (c) inside
          tdl_pkg::CL_SLASH: n = tdl_pkg::ST_CM3;
          tdl_pkg::CL_STAR:  n = tdl_pkg::ST_CM2;
          default:           n = tdl_pkg::ST_CM1;
        endcase
      end
      tdl_pkg::ST_CM3: begin
        unique case (c) inside
          tdl_pkg::CL_OTHER: n = tdl_pkg::ST_BAD;
          tdl_pkg::CL_SLASH: n = tdl_pkg::ST_CM0;
          tdl_pkg::CL_BLANK: n = tdl_pkg::ST_END;
          default:           n = tdl_pkg::ST_AGAIN;
        endcase
      end
      tdl_pkg::ST_BAD, tdl_pkg::ST_END: begin
        unique case (c) inside
          tdl_pkg::CL_BLANK: n = tdl_pkg::ST_END;
          default:           n = tdl_pkg::ST_BAD;
        endcase
      end
      tdl_pkg::ST_CM4: begin
        unique case (c) inside
          tdl_pkg::CL_SLASH: n = tdl_pkg::ST_CM5;
          default:           n = tdl_pkg::ST_CM4;
        endcase
      end
      tdl_pkg::ST_CM5: begin
        unique case (c) inside
          tdl_pkg::CL_SLASH: n = tdl_pkg::ST_BAD;
          default:           n = tdl_pkg::ST_CM4;
        endcase
      end
      tdl_pkg::ST_AGAIN: begin
        unique case (c) inside
          tdl_pkg::CL_OTHER: n = tdl_pkg::ST_BAD;
          tdl_pkg::CL_BLANK: n = tdl_pkg::ST_END;
          default:           n = tdl_pkg::ST_AGAIN;
        endcase
      end
      default: n = tdl_pkg::ST_BAD;
    endcase
    return n;
  endfunction

  // Token kind of an accepting state, or no token.
  function automatic logic [3:0] kind_of(input tdl_pkg::tdl_state_t s);
    logic [3:0] k;
    unique case (s)
      tdl_pkg::ST_IDENT: k = tdl_pkg::TK_ID;
      tdl_pkg::ST_NUM:   k = tdl_pkg::TK_NUMBER;
      tdl_pkg::ST_SGL:   k = tdl_pkg::TK_SINGLE;
      tdl_pkg::ST_FST:   k = tdl_pkg::TK_FIRST;
      tdl_pkg::ST_DBL:   k = tdl_pkg::TK_DOUBLE;
      tdl_pkg::ST_CM0:   k = tdl_pkg::TK_SLASH;
      tdl_pkg::ST_CM1:   k = tdl_pkg::TK_OPEN_CMT;
      tdl_pkg::ST_CM2:   k = tdl_pkg::TK_OPEN_STAR;
      tdl_pkg::ST_CM3, tdl_pkg::ST_CM4, tdl_pkg::ST_CM5: k = tdl_pkg::TK_COMMENT;
      default:           k = tdl_pkg::TK_NONE;
    endcase
    return k;
  endfunction

  // Error code for the state the DFA left when it hit the error.
  function automatic logic [2:0] error_of(input tdl_pkg::tdl_state_t s);
    logic [2:0] e;
    unique case (s)
      tdl_pkg::ST_IDENT:                 e = tdl_pkg::ERR_BAD_ID;
      tdl_pkg::ST_NUM:                   e = tdl_pkg::ERR_BAD_NUM;
      tdl_pkg::ST_CM3, tdl_pkg::ST_CM5:  e = tdl_pkg::ERR_NESTED_CMT;
      tdl_pkg::ST_SGL:                   e = tdl_pkg::ERR_REPEAT_DELIM;
      tdl_pkg::ST_START:                 e = tdl_pkg::ERR_ILLEGAL;
      default:                           e = tdl_pkg::ERR_NONE;
    endcase
    return e;
  endfunction

  // Builds a token result; an identifier with an exact keyword match becomes a keyword.
  function automatic tdl_pkg::tdl_result_t make_token(input tdl_pkg::tdl_state_t s,
                                                      input logic [9:0]  cand,
                                                      input logic [10:0] len,
                                                      input logic [7:0]  fb,
                                                      input logic [7:0]  sb,
                                                      input logic [15:0] line);
    tdl_pkg::tdl_result_t r;
    logic found;
    r.token_kind    = kind_of(s);
    r.keyword_index = 4'd0;
    r.error_code    = tdl_pkg::ERR_NONE;
    r.line_number   = line;
    r.token_length  = len;
    r.first_char    = fb;
    r.second_char   = sb;
    found           = 1'b0;
    for (int k = 0; k < tdl_pkg::KW_COUNT; k++) begin
      if (!found && cand[k] && (11'(tdl_pkg::KW_LEN[k]) == len)) begin
        found           = 1'b1;
        r.keyword_index = 4'(k);
      end
    end
    if (s == tdl_pkg::ST_IDENT && found) begin
      r.token_kind = tdl_pkg::TK_KEYWORD;
    end else begin
      r.keyword_index = 4'd0;
    end
    r.to_listing = (r.token_kind != tdl_pkg::TK_COMMENT);
    return r;
  endfunction

  tdl_pkg::tdl_state_t state, state_next;
  logic                skipping, skipping_next;
  tdl_pkg::tdl_state_t state_before_error, state_before_error_next;
  logic [9:0]          kw_cand, kw_cand_next;
  logic [10:0]         length_count, length_count_next;
  logic [7:0]          first_byte, first_byte_next;
  logic [7:0]          second_byte, second_byte_next;
  logic [15:0]         line_count, line_count_next;

  tdl_pkg::tdl_class_t cls;
  logic [7:0]          low;
  tdl_pkg::tdl_state_t next_raw, next_eff;
  logic                restart;
  logic [10:0]         base_len, take_len;
  logic [7:0]          base_fb, take_fb, base_sb, take_sb;
  logic [9:0]          base_cand, take_cand;
  tdl_pkg::tdl_result_t tok_now, tok_cap, err_now;
  logic                tok_now_has, tok_cap_has, err_now_has;

  // Class, DFA lookup and a second lookup from the start state for a byte that
  // closes the current token and opens a new one.
  always_comb begin
    cls      = byte_class(item.char_byte);
    low      = (item.char_byte >= 8'h41 && item.char_byte <= 8'h5A) ?
               8'(item.char_byte + 8'h20) : item.char_byte;
    next_raw = next_state(state, cls);
    restart  = (next_raw == tdl_pkg::ST_AGAIN);
    next_eff = restart ? next_state(tdl_pkg::ST_START, cls) : next_raw;
  end

  // Append the byte to the token text, from a fresh token after a restart.
  always_comb begin
    base_len  = restart ? 11'd0 : length_count;
    base_fb   = restart ? 8'd0 : first_byte;
    base_sb   = restart ? 8'd0 : second_byte;
    base_cand = restart ? '1 : kw_cand;
    take_len  = base_len;
    take_fb   = base_fb;
    take_sb   = base_sb;
    take_cand = base_cand;
    if (base_len < LEN_CAP) begin
      take_len = 11'(base_len + 11'd1);
      if (base_len == 11'd0) begin
        take_fb = item.char_byte;
      end
      if (base_len == 11'd1) begin
        take_sb = item.char_byte;
      end
      for (int k = 0; k < tdl_pkg::KW_COUNT; k++) begin
        if ((base_len >= 11'(tdl_pkg::KW_LEN[k])) ||
            (tdl_pkg::KW_TEXT[k][base_len[2:0]] != low)) begin
          take_cand[k] = 1'b0;
        end
      end
    end
  end

  // Candidate results: the token as it stands, the token that just hit the
  // length cap, and the pending error.
  always_comb begin
    tok_now     = make_token(state, kw_cand, length_count, first_byte, second_byte,
                             line_count);
    tok_now_has = (kind_of(state) != tdl_pkg::TK_NONE);
    tok_cap     = make_token(next_eff, take_cand, take_len, take_fb, take_sb, line_count);
    tok_cap_has = (kind_of(next_eff) != tdl_pkg::TK_NONE);
    err_now.token_kind    = tdl_pkg::TK_ERROR;
    err_now.keyword_index = 4'd0;
    err_now.error_code    = error_of(state_before_error);
    err_now.line_number   = line_count;
    err_now.token_length  = length_count;
    err_now.first_char    = first_byte;
    err_now.second_char   = second_byte;
    err_now.to_listing    = 1'b1;
    err_now_has           = (err_now.error_code != tdl_pkg::ERR_NONE);
  end

  // Next state and result of one step.
  always_comb begin
    state_next              = state;
    skipping_next           = skipping;
    state_before_error_next = state_before_error;
    kw_cand_next            = kw_cand;
    length_count_next       = length_count;
    first_byte_next         = first_byte;
    second_byte_next        = second_byte;
    line_count_next         = line_count;
    emit                    = 1'b0;
    result                  = tok_now;
    if (item.end_of_input) begin
      // End of input closes the token or the pending error.
      emit   = skipping ? err_now_has : tok_now_has;
      result = skipping ? err_now : tok_now;
      state_next = tdl_pkg::ST_START;
      skipping_next = 1'b0;
      state_before_error_next = tdl_pkg::ST_START;
      kw_cand_next = '1;
      length_count_next = 11'd0;
      first_byte_next = 8'd0;
      second_byte_next = 8'd0;
    end else if (skipping) begin
      // Error skip runs to the next blank; newlines are absorbed uncounted.
      if (cls == tdl_pkg::CL_BLANK) begin
        emit   = err_now_has;
        result = err_now;
        state_next = tdl_pkg::ST_START;
        skipping_next = 1'b0;
        state_before_error_next = tdl_pkg::ST_START;
        kw_cand_next = '1;
        length_count_next = 11'd0;
        first_byte_next = 8'd0;
        second_byte_next = 8'd0;
      end else begin
        kw_cand_next      = take_cand;
        length_count_next = take_len;
        first_byte_next   = take_fb;
        second_byte_next  = take_sb;
      end
    end else if (item.char_byte == tdl_pkg::CHAR_NEWLINE) begin
      // Newline closes the token on the current line, then the line advances.
      emit   = tok_now_has;
      result = tok_now;
      state_next = tdl_pkg::ST_START;
      state_before_error_next = tdl_pkg::ST_START;
      kw_cand_next = '1;
      length_count_next = 11'd0;
      first_byte_next = 8'd0;
      second_byte_next = 8'd0;
      if (line_count != 16'hFFFF) begin
        line_count_next = 16'(line_count + 16'd1);
      end
    end else begin
      // A byte that cannot extend the token closes it first.
      if (restart) begin
        emit   = tok_now_has;
        result = tok_now;
      end
      if (next_eff == tdl_pkg::ST_BAD) begin
        state_before_error_next = restart ? tdl_pkg::ST_START : state;
        skipping_next     = 1'b1;
        state_next        = tdl_pkg::ST_BAD;
        kw_cand_next      = take_cand;
        length_count_next = take_len;
        first_byte_next   = take_fb;
        second_byte_next  = take_sb;
      end else if (next_eff == tdl_pkg::ST_END) begin
        // A blank closes the token and is dropped.
        emit   = tok_now_has;
        result = tok_now;
        state_next = tdl_pkg::ST_START;
        state_before_error_next = tdl_pkg::ST_START;
        kw_cand_next = '1;
        length_count_next = 11'd0;
        first_byte_next = 8'd0;
        second_byte_next = 8'd0;
      end else begin
        state_next        = next_eff;
        kw_cand_next      = take_cand;
        length_count_next = take_len;
        first_byte_next   = take_fb;
        second_byte_next  = take_sb;
        // A token that reaches the length cap closes with this byte.
        if (take_len >= LEN_CAP && !restart) begin
          emit   = tok_cap_has;
          result = tok_cap;
          state_next = tdl_pkg::ST_START;
          state_before_error_next = tdl_pkg::ST_START;
          kw_cand_next = '1;
          length_count_next = 11'd0;
          first_byte_next = 8'd0;
          second_byte_next = 8'd0;
        end
      end
    end
  end

  // Lexer state registers, updated once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= tdl_pkg::ST_START;
      skipping           <= 1'b0;
      state_before_error <= tdl_pkg::ST_START;
      kw_cand            <= '1;
      length_count       <= 11'd0;
      first_byte         <= 8'd0;
      second_byte        <= 8'd0;
      line_count         <= 16'd1;
    end else if (step) begin
      state              <= state_next;
      skipping           <= skipping_next;
      state_before_error <= state_before_error_next;
      kw_cand            <= kw_cand_next;
      length_count       <= length_count_next;
      first_byte         <= first_byte_next;
      second_byte        <= second_byte_next;
      line_count         <= line_count_next;
    end
  end

endmodule

[hdl/tdl_out_stage.sv]
// Result register of the lexer core with its valid/stall handshake.
`timescale 1ns / 1ps

module tdl_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 emit,
  input  tdl_pkg::tdl_result_t result,
  output logic                 advance,
  output logic                 token_valid,
  input  logic                 token_stall,
  output tdl_pkg::tdl_result_t held_result
);

  // The register may be overwritten when empty or when its item is taken.
  assign advance = !token_valid || !token_stall;

  // Valid bit of the held result item.
  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (advance) begin
      token_valid <= step && emit;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (advance && step && emit) begin
      held_result <= result;
    end
  end

endmodule

[hdl/table_driven_lexer_core.sv]
// Top level of the table-driven lexer core: input register, DFA step, result register.
// A result item is built by the DFA step from the input register and held in the result register.
// Throughput: one input item per cycle while the result side does not stall; the DFA step works on the held input item.
// Stalls on the result side back up through the input register only when both are full.
// Reset (rst, synchronous): start state, empty token, line count one; no clearing pass.
`timescale 1ns / 1ps
`include "table_driven_lexer_core_defines.svh"

module table_driven_lexer_core #(
  parameter int MAX_TOKEN = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  char_byte,
  input  logic        end_of_input,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [3:0]  token_kind,
  output logic [3:0]  keyword_index,
  output logic [2:0]  error_code,
  output logic [15:0] line_number,
  output logic [10:0] token_length,
  output logic [7:0]  first_char,
  output logic [7:0]  second_char,
  output logic        to_listing
);

  logic                 held_valid;
  tdl_pkg::tdl_item_t   held_item;
  logic                 advance;
  logic                 step;
  logic                 emit;
  tdl_pkg::tdl_result_t result;
  tdl_pkg::tdl_result_t held_result;

  // Input register.
  tdl_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .char_byte    (char_byte),
    .end_of_input (end_of_input),
    .advance      (advance),
    .held_valid   (held_valid),
    .held_item    (held_item)
  );

  // The held item is processed when the result register can take its output.
  assign step = held_valid && advance;

  tdl_scan #(
    .MAX_TOKEN (MAX_TOKEN)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (held_item),
    .emit   (emit),
    .result (result)
  );

  // Result register.
  tdl_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .emit        (emit),
    .result      (result),
    .advance     (advance),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .held_result (held_result)
  );

  // Result fields to the ports.
  assign token_kind    = held_result.token_kind;
  assign keyword_index = held_result.keyword_index;
  assign error_code    = held_result.error_code;
  assign line_number   = held_result.line_number;
  assign token_length  = held_result.token_length;
  assign first_char    = held_result.first_char;
  assign second_char   = held_result.second_char;
  assign to_listing    = held_result.to_listing;

  // Checks on the pipeline and the result stream.
  `TDL_ASSERT_HOLDS(a_stall_full, item_stall, held_valid && token_valid && token_stall, "stall")
  `TDL_ASSERT_NEXT(a_line_mono, token_valid && !token_stall, line_number >= $past(line_number), "line")
  `TDL_ASSERT_HOLDS(a_err_code, token_valid, (token_kind == tdl_pkg::TK_ERROR) == (error_code != tdl_pkg::ERR_NONE), "err")

endmodule

[sim/tdl_token_checker.sv]
// Token checker for the lexer core: predicts token items from input items and compares them.
`timescale 1ns / 1ps

module tdl_token_checker
  import tdl_pkg::*;
#(
  parameter int MAX_TOKEN = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic [7:0]  char_byte,
  input  logic        end_of_input,
  input  logic        token_valid,
  input  logic        token_stall,
  input  logic [3:0]  token_kind,
  input  logic [3:0]  keyword_index,
  input  logic [2:0]  error_code,
  input  logic [15:0] line_number,
  input  logic [10:0] token_length,
  input  logic [7:0]  first_char,
  input  logic [7:0]  second_char,
  input  logic        to_listing,
  output int          fail_count,
  output int          pending
);

  // Token length cap; the length field is only 11 bits wide.
  localparam int LEN_CAP = (MAX_TOKEN < 2047) ? MAX_TOKEN : 2047;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  // Token items predicted but not yet seen on the result channel.
  tdl_result_t token_queue[$];

  // Lexer state as tracked by the predictor.
  tdl_state_t  lx_state;
  bit          lx_skip;
  tdl_state_t  lx_prior;
  logic [9:0]  lx_cand;
  int          lx_len;
  logic [7:0]  lx_first;
  logic [7:0]  lx_second;
  logic [15:0] lx_line;

  // Keyword spellings, in keyword index order.
  function automatic string keyword_text(int k);
    case (k)
      0: return "if";
      1: return "else";
      2: return "for";
      3: return "while";
      4: return "do";
      5: return "int";
      6: return "write";
      7: return "read";
      8: return "return";
      default: return "call";
    endcase
  endfunction

  // Sort a byte into its character class.
  function automatic tdl_class_t char_class(logic [7:0] c);
    if (c >= "0" && c <= "9") return CL_DIGIT;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return CL_LETTER;
    case (c)
      "+", "-", ":", "(", ")", "[", "]", "{", "}", ",", ";": return CL_SINGLE;
      ">", "<", "!": return CL_REL;
      "=": return CL_EQUAL;
      "/": return CL_SLASH;
      "*": return CL_STAR;
      " ", CHAR_TAB: return CL_BLANK;
      default: return CL_OTHER;
    endcase
  endfunction

  // Transition table; each row lists other, digit, letter, single, rel, equal,
  // slash, star and blank in that order.
  function automatic tdl_state_t next_state(tdl_state_t s, tdl_class_t cls);
    logic [0:8][3:0] row;
    case (s)
      ST_START: row = {ST_BAD, ST_NUM, ST_IDENT, ST_SGL, ST_FST, ST_FST, ST_CM0, ST_SGL,
                       ST_END};
      ST_IDENT: row = {ST_BAD, ST_IDENT, ST_IDENT, ST_AGAIN, ST_AGAIN, ST_AGAIN, ST_AGAIN,
                       ST_AGAIN, ST_END};
      ST_NUM:   row = {ST_BAD, ST_NUM, ST_BAD, ST_AGAIN, ST_AGAIN, ST_AGAIN, ST_AGAIN,
                       ST_AGAIN, ST_END};
      ST_SGL:   row = {ST_BAD, ST_AGAIN, ST_AGAIN, ST_AGAIN, ST_AGAIN, ST_AGAIN, ST_BAD,
                       ST_BAD, ST_END};
      ST_FST:   row = {ST_BAD, ST_AGAIN, ST_AGAIN, ST_BAD, ST_BAD, ST_DBL, ST_BAD, ST_BAD,
                       ST_END};
      ST_DBL:   row = {ST_BAD, ST_AGAIN, ST_AGAIN, ST_AGAIN, ST_BAD, ST_AGAIN, ST_BAD,
                       ST_BAD, ST_END};
      ST_CM0:   row = {ST_BAD, ST_BAD, ST_BAD, ST_BAD, ST_BAD, ST_BAD, ST_CM4, ST_CM1,
                       ST_END};
      ST_CM1:   row = {ST_CM1, ST_CM1, ST_CM1, ST_CM1, ST_CM1, ST_CM1, ST_CM1, ST_CM2,
                       ST_CM1};
      ST_CM2:   row = {ST_CM1, ST_CM1, ST_CM1, ST_CM1, ST_CM1, ST_CM1, ST_CM3, ST_CM2,
                       ST_CM1};
      ST_CM3:   row = {ST_BAD, ST_AGAIN, ST_AGAIN, ST_AGAIN, ST_AGAIN, ST_AGAIN, ST_CM0,
                       ST_AGAIN, ST_END};
      ST_CM4:   row = {ST_CM4, ST_CM4, ST_CM4, ST_CM4, ST_CM4, ST_CM4, ST_CM5, ST_CM4,
                       ST_CM4};
      ST_CM5:   row = {ST_CM4, ST_CM4, ST_CM4, ST_CM4, ST_CM4, ST_CM4, ST_BAD, ST_CM4,
                       ST_CM4};
      ST_AGAIN: row = {ST_BAD, ST_AGAIN, ST_AGAIN, ST_AGAIN, ST_AGAIN, ST_AGAIN, ST_AGAIN,
                       ST_AGAIN, ST_END};
      default:  row = {ST_BAD, ST_BAD, ST_BAD, ST_BAD, ST_BAD, ST_BAD, ST_BAD, ST_BAD,
                       ST_END};
    endcase
    return tdl_state_t'(row[cls]);
  endfunction

  // Token kind of an accepting state, or none.
  function automatic logic [3:0] token_kind_of(tdl_state_t s);
    case (s)
      ST_IDENT: return TK_ID;
      ST_NUM:   return TK_NUMBER;
      ST_SGL:   return TK_SINGLE;
      ST_FST:   return TK_FIRST;
      ST_DBL:   return TK_DOUBLE;
      ST_CM0:   return TK_SLASH;
      ST_CM1:   return TK_OPEN_CMT;
      ST_CM2:   return TK_OPEN_STAR;
      ST_CM3, ST_CM4, ST_CM5: return TK_COMMENT;
      default:  return TK_NONE;
    endcase
  endfunction

  // Drop the current token and return to the start state.
  function automatic void clear_token();
    lx_state  = ST_START;
    lx_skip   = 1'b0;
    lx_prior  = ST_START;
    lx_cand   = '1;
    lx_len    = 0;
    lx_first  = 8'h00;
    lx_second = 8'h00;
  endfunction

  // Add a byte to the token text and narrow the keyword candidates.
  function automatic void take_char(logic [7:0] c);
    logic [7:0] low;
    string w;
    low = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    if (lx_len < LEN_CAP) begin
      if (lx_len == 0) lx_first = c;
      if (lx_len == 1) lx_second = c;
      for (int k = 0; k < 10; k++) begin
        w = keyword_text(k);
        if (lx_len >= w.len() || w[lx_len] != low) lx_cand[k] = 1'b0;
      end
      lx_len++;
    end
  endfunction

  // Queue one expected token item built from the current token.
  function automatic bit push_token(logic [3:0] kind, logic [3:0] kwi, logic [2:0] err);
    tdl_result_t r;
    r.token_kind    = kind;
    r.keyword_index = kwi;
    r.error_code    = err;
    r.line_number   = lx_line;
    r.token_length  = lx_len[10:0];
    r.first_char    = lx_first;
    r.second_char   = lx_second;
    r.to_listing    = (kind != TK_COMMENT);
    token_queue.push_back(r);
    return 1'b1;
  endfunction

  // Close the current token; identifiers that spell a keyword become keywords.
  function automatic bit close_token();
    logic [3:0] kind;
    kind = token_kind_of(lx_state);
    if (kind == TK_NONE) return 1'b0;
    if (lx_state == ST_IDENT) begin
      for (int k = 0; k < 10; k++) begin
        if (lx_cand[k] && keyword_text(k).len() == lx_len)
          return push_token(TK_KEYWORD, 4'(k), ERR_NONE);
      end
    end
    return push_token(kind, 4'd0, ERR_NONE);
  endfunction

  // Close a skipped error; some prior states carry no message.
  function automatic bit close_error();
    case (lx_prior)
      ST_IDENT:       return push_token(TK_ERROR, 4'd0, ERR_BAD_ID);
      ST_NUM:         return push_token(TK_ERROR, 4'd0, ERR_BAD_NUM);
      ST_CM3, ST_CM5: return push_token(TK_ERROR, 4'd0, ERR_NESTED_CMT);
      ST_SGL:         return push_token(TK_ERROR, 4'd0, ERR_REPEAT_DELIM);
      ST_START:       return push_token(TK_ERROR, 4'd0, ERR_ILLEGAL);
      default:        return 1'b0;
    endcase
  endfunction

  // Advance the lexer by one input item, queueing any token it closes.
  task automatic lex_step(input logic [7:0] c, input logic eoi);
    tdl_class_t cls;
    tdl_state_t nxt;
    bit got;
    got = 1'b0;
    if (eoi) begin
      got = lx_skip ? close_error() : close_token();
      clear_token();
    end else if (lx_skip) begin
      // Error skip runs to the next blank; newlines are swallowed uncounted.
      if (char_class(c) == CL_BLANK) begin
        got = close_error();
        clear_token();
      end else begin
        take_char(c);
      end
    end else if (c == CHAR_NEWLINE) begin
      got = close_token();
      clear_token();
      if (lx_line != 16'hFFFF) lx_line++;
    end else begin
      cls = char_class(c);
      nxt = next_state(lx_state, cls);
      // A byte that cannot extend the token closes it and starts over.
      if (nxt == ST_AGAIN) begin
        got = close_token();
        clear_token();
        nxt = next_state(ST_START, cls);
      end
      if (nxt == ST_BAD) begin
        lx_prior = lx_state;
        lx_skip  = 1'b1;
        lx_state = ST_BAD;
        take_char(c);
      end else if (nxt == ST_END) begin
        if (!got) got = close_token();
        clear_token();
      end else begin
        lx_state = nxt;
        take_char(c);
        if (lx_len >= LEN_CAP && !got) begin
          got = close_token();
          clear_token();
        end
      end
    end
  endtask

  // Print one mismatch line and count it; printing stops after 200 mismatches.
  task automatic report_mismatch(input string what, input logic [15:0] got_v,
                                 input logic [15:0] want_v);
    if (fail_count < 200)
      $display("%0t ns: token %s mismatch, got %0d, wanted %0d", $time, what, got_v, want_v);
    fail_count++;
  endtask

  // Watch both channels: compare each result item, then predict from each input item.
  always @(posedge clk) begin : watch
    tdl_result_t want;
    if (rst) begin
      clear_token();
      lx_line = 16'd1;
      token_queue.delete();
      fail_count = 0;
    end else begin
      if (token_valid && !token_stall) begin
        if (token_queue.size() == 0) begin
          report_mismatch("item without prediction", {12'd0, token_kind}, 16'd0);
        end else begin
          want = token_queue.pop_front();
          if (token_kind !== want.token_kind)
            report_mismatch("kind", {12'd0, token_kind}, {12'd0, want.token_kind});
          if (keyword_index !== want.keyword_index)
            report_mismatch("keyword_index", {12'd0, keyword_index},
                            {12'd0, want.keyword_index});
          if (error_code !== want.error_code)
            report_mismatch("error_code", {13'd0, error_code}, {13'd0, want.error_code});
          if (line_number !== want.line_number)
            report_mismatch("line_number", line_number, want.line_number);
          if (token_length !== want.token_length)
            report_mismatch("length", {5'd0, token_length}, {5'd0, want.token_length});
          if (first_char !== want.first_char)
            report_mismatch("first_char", {8'd0, first_char}, {8'd0, want.first_char});
          if (second_char !== want.second_char)
            report_mismatch("second_char", {8'd0, second_char}, {8'd0, want.second_char});
          if (to_listing !== want.to_listing)
            report_mismatch("to_listing", {15'd0, to_listing}, {15'd0, want.to_listing});
        end
      end
      if (item_valid && !item_stall) lex_step(char_byte, end_of_input);
    end
    pending <= token_queue.size();
  end

endmodule

[sim/tb_top.sv]
// Testbench top for the lexer core: drives source bytes, stalls results and gives the verdict.
`timescale 1ns / 1ps

module tb_top;
  import tdl_pkg::*;

  localparam int MAX_TOKEN = 1024;
  localparam int RANDOM_ITEMS = 1110;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [7:0]  char_byte = 8'h00;
  logic        end_of_input = 1'b0;
  logic        token_valid;
  logic        token_stall = 1'b0;
  logic [3:0]  token_kind;
  logic [3:0]  keyword_index;
  logic [2:0]  error_code;
  logic [15:0] line_number;
  logic [10:0] token_length;
  logic [7:0]  first_char;
  logic [7:0]  second_char;
  logic        to_listing;

  int fail_count;
  int pending;
  int items_sent = 0;
  int rx_wait = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  table_driven_lexer_core #(
    .MAX_TOKEN(MAX_TOKEN)
  ) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .char_byte(char_byte),
    .end_of_input(end_of_input),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token_kind(token_kind),
    .keyword_index(keyword_index),
    .error_code(error_code),
    .line_number(line_number),
    .token_length(token_length),
    .first_char(first_char),
    .second_char(second_char),
    .to_listing(to_listing)
  );

  tdl_token_checker #(
    .MAX_TOKEN(MAX_TOKEN)
  ) token_check (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .char_byte(char_byte),
    .end_of_input(end_of_input),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token_kind(token_kind),
    .keyword_index(keyword_index),
    .error_code(error_code),
    .line_number(line_number),
    .token_length(token_length),
    .first_char(first_char),
    .second_char(second_char),
    .to_listing(to_listing),
    .fail_count(fail_count),
    .pending(pending)
  );

  // 20 ns clock.
  always #10 clk = ~clk;

  // Result side: after each accepted item, stall for a random number of cycles.
  always @(posedge clk) begin : receiver
    int w;
    if (rst) begin
      token_stall <= 1'b0;
      rx_wait <= 0;
    end else if (token_valid && !token_stall) begin
      if ($urandom_range(0, 15) == 0) rx_quiet = ~rx_quiet;
      w = rx_quiet ? 0 : int'($urandom_range(0, 15));
      rx_wait <= w;
      token_stall <= (w != 0);
    end else if (rx_wait > 1) begin
      rx_wait <= rx_wait - 1;
    end else begin
      rx_wait <= 0;
      token_stall <= 1'b0;
    end
  end

  function automatic string keyword_word(int k);
    case (k)
      0: return "if";
      1: return "else";
      2: return "for";
      3: return "while";
      4: return "do";
      5: return "int";
      6: return "write";
      7: return "read";
      8: return "return";
      default: return "call";
    endcase
  endfunction

  // One random byte out of a string.
  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] random_letter();
    logic [7:0] c;
    c = 8'("a" + $urandom_range(0, 25));
    if ($urandom_range(0, 1) == 1) c = c - 8'd32;
    return c;
  endfunction

  function automatic logic [7:0] random_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  // Comment text: printable bytes with stars and slashes mixed in.
  function automatic logic [7:0] comment_char();
    if ($urandom_range(0, 3) == 0) return pick("*/");
    return 8'($urandom_range(32, 126));
  endfunction

  // Offer one input item after a random gap and hold it until accepted.
  task automatic send_item(input logic [7:0] c, input logic eoi);
    int gap;
    gap = tx_quiet ? 0 : int'($urandom_range(0, 15));
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    char_byte <= c;
    end_of_input <= eoi;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // Stop sending and wait until every predicted token item has come out.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One random fragment of source text, mostly well formed.
  task automatic send_fragment();
    string w;
    logic [7:0] c;
    int n;
    case ($urandom_range(0, 15))
      0, 1, 2: begin
        // Keyword in mixed case, sometimes with a trailing letter.
        w = keyword_word($urandom_range(0, 9));
        for (int i = 0; i < w.len(); i++) begin
          c = w[i];
          if ($urandom_range(0, 1) == 1) c = c - 8'd32;
          send_item(c, 1'b0);
        end
        if ($urandom_range(0, 3) == 0) send_item(random_letter(), 1'b0);
      end
      3: begin
        send_item(random_letter(), 1'b0);
        n = $urandom_range(0, 7);
        repeat (n) send_item(($urandom_range(0, 1) == 1) ? random_letter() : random_digit(),
                             1'b0);
      end
      4: begin
        // Number, sometimes broken by a letter.
        n = $urandom_range(1, 6);
        repeat (n) send_item(random_digit(), 1'b0);
        if ($urandom_range(0, 3) == 0) send_item(random_letter(), 1'b0);
      end
      5: begin
        send_item(pick("+-:()[]{},;"), 1'b0);
        if ($urandom_range(0, 2) == 0) send_item(pick("+-:()[]{},;/*"), 1'b0);
      end
      6: begin
        send_item(pick("<>!"), 1'b0);
        if ($urandom_range(0, 1) == 1) send_item("=", 1'b0);
        if ($urandom_range(0, 3) == 0) send_item(pick("<>!=/*+"), 1'b0);
      end
      7: begin
        send_item("=", 1'b0);
        if ($urandom_range(0, 1) == 1) send_item("=", 1'b0);
      end
      8: begin
        // Block comment, sometimes left open or followed by a stray byte.
        send_text("/*");
        n = $urandom_range(0, 12);
        repeat (n) send_item(comment_char(), 1'b0);
        if ($urandom_range(0, 4) != 0) send_text(($urandom_range(0, 3) == 0) ? "**/" : "*/");
        if ($urandom_range(0, 3) == 0) send_item(pick("/a1;$*"), 1'b0);
      end
      9: begin
        // Line comment, sometimes with a nested opener.
        send_text("//");
        n = $urandom_range(0, 12);
        repeat (n) send_item(comment_char(), 1'b0);
        if ($urandom_range(0, 2) == 0) send_item("/", 1'b0);
        send_item(CHAR_NEWLINE, 1'b0);
      end
      10, 11: send_item(pick("  \t"), 1'b0);
      12: send_item(CHAR_NEWLINE, 1'b0);
      13: send_item(8'($urandom_range(0, 255)), 1'b0);
      14: send_item(8'($urandom_range(0, 255)), 1'b1);
      default: begin
        send_item("/", 1'b0);
        if ($urandom_range(0, 1) == 1) send_item(pick(" *a"), 1'b0);
      end
    endcase
    if ($urandom_range(0, 1) == 1) send_item(pick("    \t\n"), 1'b0);
  endtask

  // Stimulus: reset, directed items, random fragments, then closing tokens.
  initial begin : stimulus
    int target;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Keyword in mixed case, number cut by a delimiter, double delimiter, newline.
    send_text("WhILe ");
    send_text("7;");
    send_text("<=\n");
    // Bad identifier byte, then a slash followed by a letter that the DFA rejects, closed by end of input.
    send_item("x", 1'b0);
    send_item(8'hFF, 1'b0);
    send_text(" /a");
    send_item(8'h00, 1'b1);
    // Open comment ending in a star, closed by end of input.
    send_text("/**");
    send_item(8'hA5, 1'b1);
    // Illegal byte whose skip swallows a carriage return and a newline.
    send_item(8'h00, 1'b0);
    send_item(8'h0D, 1'b0);
    send_item(CHAR_NEWLINE, 1'b0);
    send_text("q ");
    wait_drained();

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 15) == 0) tx_quiet = ~tx_quiet;
      send_fragment();
    end
    tx_quiet = 1'b0;
    wait_drained();

    // A token closed by a blank, then a keyword closed by end of input.
    send_text("ab ");
    send_item(8'h00, 1'b1);
    send_text("Do");
    send_item(8'h00, 1'b1);

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[table_driven_lexer_core] OK");
    end else begin
      $display("[table_driven_lexer_core] ERROR");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin : watchdog
    #20_000_000;
    $display("[table_driven_lexer_core] ERROR");
    $finish;
  end

endmodule
